// ===== rtl/core/era_pkg.sv =====
// shared constants, codes and controller/datapath link types for the record allocator
package era_pkg;

  localparam int STORE_BYTES  = 1024;
  localparam int HEADER_BYTES = 5;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  // a walk address can step past the store by a header and a full 16-bit length
  localparam int WALK_W       = $clog2(STORE_BYTES + HEADER_BYTES + 65536);

  localparam logic [7:0] MARK_LIVE  = 8'd42;
  localparam logic [7:0] MARK_FREED = 8'h80;
  localparam logic [7:0] ERASED     = 8'hFF;

  // request codes
  localparam logic [2:0] REQ_WOPEN = 3'd0;
  localparam logic [2:0] REQ_WBYTE = 3'd1;
  localparam logic [2:0] REQ_ROPEN = 3'd2;
  localparam logic [2:0] REQ_RBYTE = 3'd3;
  localparam logic [2:0] REQ_FREE  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ID_EXISTS = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;
  localparam logic [2:0] ST_NOTHING   = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_START,
    OP_ISSUE,
    OP_CAPTURE,
    OP_ADVANCE,
    OP_KCLR,
    OP_HDR_WRITE,
    OP_WOPEN,
    OP_ROPEN,
    OP_FREE,
    OP_WBYTE,
    OP_RB_ISSUE,
    OP_RB_CAPTURE
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       set_status;
    logic [2:0] status;
    logic       push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic [2:0] req_type;
    logic       k_last;
    logic       walk_end;
    logic       is_marker;
    logic       is_freed;
    logic       id_match;
    logic       len_match;
    logic       fits;
    logic       write_left_nz;
    logic       read_left_nz;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/era_req_if.sv =====
// request channel: valid/ready handshake with the request fields
interface era_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] record_id;
  logic [9:0]  record_length;
  logic [7:0]  data_byte;

  modport source (output valid, req_type, record_id, record_length, data_byte, input ready);
  modport sink   (input valid, req_type, record_id, record_length, data_byte, output ready);
endinterface

// ===== rtl/core/era_rsp_if.sv =====
// result channel: valid/ready handshake with the result fields
interface era_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] read_byte_value;
  logic [9:0] granted_length;
  logic [9:0] record_address;

  modport source (output valid, status, read_byte_value, granted_length, record_address,
                  input ready);
  modport sink   (input valid, status, read_byte_value, granted_length, record_address,
                  output ready);
endinterface

// ===== rtl/core/era_ram.sv =====
// generic single-write, single-read ram with registered read data
module era_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/era_dpath.sv =====
// datapath: store, walk address, header capture, stream pointers and result register
module era_dpath (
  input  logic               clk,
  input  logic               rst,
  input  era_pkg::ctrl_cmd_t cmd,
  output era_pkg::dp_stat_t  stat,
  input  logic [2:0]         in_req_type,
  input  logic [15:0]        in_record_id,
  input  logic [9:0]         in_record_length,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [7:0]         out_read_byte_value,
  output logic [9:0]         out_granted_length,
  output logic [9:0]         out_record_address
);
  import era_pkg::*;

  logic [2:0]        req_type;
  logic [15:0]       req_id;
  logic [9:0]        req_len;
  logic [7:0]        req_data;

  logic [ADDR_W-1:0] clr_cnt;
  logic [WALK_W-1:0] walk_addr;
  logic [2:0]        k;
  logic [7:0]        hdr [HEADER_BYTES];
  logic              beyond;

  logic [ADDR_W-1:0] write_pointer;
  logic [9:0]        write_left;
  logic [ADDR_W-1:0] read_pointer;
  logic [9:0]        read_left;

  logic [2:0]        res_status;
  logic [7:0]        res_value;
  logic [9:0]        res_granted;
  logic [9:0]        res_addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic [WALK_W-1:0] rd_addr;
  logic [15:0]       hdr_id;
  logic [15:0]       hdr_len;
  logic [WALK_W:0]   end_sum;
  logic [9:0]        granted;
  logic              out_free;

  era_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // header decode and bound checks
  assign rd_addr  = walk_addr + WALK_W'(k);
  assign hdr_id   = {hdr[2], hdr[1]};
  assign hdr_len  = {hdr[4], hdr[3]};
  assign end_sum  = (WALK_W+1)'(walk_addr) + (WALK_W+1)'(HEADER_BYTES) + (WALK_W+1)'(req_len);
  assign granted  = (hdr_len < {6'd0, req_len}) ? hdr_len[9:0] : req_len;
  assign out_free = !out_valid || out_ready;

  assign stat.clear_done    = (clr_cnt == ADDR_W'(STORE_BYTES - 1));
  assign stat.req_type      = req_type;
  assign stat.k_last        = (k == 3'(HEADER_BYTES - 1));
  assign stat.walk_end      = (walk_addr >= WALK_W'(STORE_BYTES));
  assign stat.is_marker     = (hdr[0][6:0] == MARK_LIVE[6:0]);
  assign stat.is_freed      = hdr[0][7];
  assign stat.id_match      = (hdr_id == req_id);
  assign stat.len_match     = (hdr_len == {6'd0, req_len});
  assign stat.fits          = (end_sum < (WALK_W+1)'(STORE_BYTES));
  assign stat.write_left_nz = (write_left != 10'd0);
  assign stat.read_left_nz  = (read_left != 10'd0);
  assign stat.out_free      = out_free;

  // store write and read address selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = walk_addr[ADDR_W-1:0];
    ram_wdata = ERASED;
    ram_raddr = read_pointer;
    case (cmd.op)
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      OP_HDR_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = walk_addr[ADDR_W-1:0] + ADDR_W'(k);
        case (k)
          3'd0:    ram_wdata = MARK_LIVE;
          3'd1:    ram_wdata = req_id[7:0];
          3'd2:    ram_wdata = req_id[15:8];
          3'd3:    ram_wdata = req_len[7:0];
          default: ram_wdata = {6'd0, req_len[9:8]};
        endcase
      end
      OP_FREE: begin
        ram_we    = 1'b1;
        ram_wdata = MARK_LIVE | MARK_FREED;
      end
      OP_WBYTE: begin
        ram_we    = 1'b1;
        ram_waddr = write_pointer;
        ram_wdata = req_data;
      end
      OP_ISSUE: ram_raddr = rd_addr[ADDR_W-1:0];
      default:  ram_raddr = read_pointer;
    endcase
  end

  // request latch, walk registers, header capture and stream pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt       <= '0;
      write_pointer <= '0;
      write_left    <= '0;
      read_pointer  <= '0;
      read_left     <= '0;
      walk_addr     <= '0;
      k             <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        OP_LOAD: begin
          req_type    <= in_req_type;
          req_id      <= in_record_id;
          req_len     <= in_record_length;
          req_data    <= in_data_byte;
          walk_addr   <= '0;
          k           <= '0;
          res_value   <= '0;
          res_granted <= '0;
          res_addr    <= '0;
          if (in_req_type == REQ_WOPEN) begin
            write_left <= '0;
          end
          if (in_req_type == REQ_ROPEN) begin
            read_left <= '0;
          end
        end
        OP_START: begin
          walk_addr <= '0;
          k         <= '0;
        end
        OP_ISSUE: beyond <= (rd_addr >= WALK_W'(STORE_BYTES));
        OP_CAPTURE: begin
          hdr[k] <= beyond ? ERASED : ram_rdata;
          k      <= k + 1'b1;
        end
        OP_ADVANCE: begin
          walk_addr <= walk_addr + WALK_W'(HEADER_BYTES) + WALK_W'(hdr_len);
          k         <= '0;
        end
        OP_KCLR: k <= '0;
        OP_HDR_WRITE: k <= k + 1'b1;
        OP_WOPEN: begin
          write_pointer <= walk_addr[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
          write_left    <= req_len;
          res_addr      <= walk_addr[9:0];
        end
        OP_ROPEN: begin
          read_pointer <= walk_addr[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
          read_left    <= granted;
          res_granted  <= granted;
          res_addr     <= walk_addr[9:0];
        end
        OP_FREE: res_addr <= walk_addr[9:0];
        OP_WBYTE: begin
          write_pointer <= write_pointer + 1'b1;
          write_left    <= write_left - 1'b1;
        end
        OP_RB_CAPTURE: begin
          res_value    <= ram_rdata;
          read_pointer <= read_pointer + 1'b1;
          read_left    <= read_left - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      res_status <= ST_OK;
    end else if (cmd.set_status) begin
      res_status <= cmd.status;
    end
  end

  // output register, parts the result channel from the request side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_status          <= res_status;
      out_read_byte_value <= res_value;
      out_granted_length  <= res_granted;
      out_record_address  <= res_addr;
    end
  end

  // write stream stays inside the store
  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    (WALK_W'(write_pointer) + WALK_W'(write_left)) < WALK_W'(STORE_BYTES))
    else $error("write stream runs past the store");

  // read stream stays inside the store
  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    (WALK_W'(read_pointer) + WALK_W'(read_left)) < WALK_W'(STORE_BYTES))
    else $error("read stream runs past the store");

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> out_free)
    else $error("result register overwritten while stalled");

endmodule

// ===== rtl/core/era_ctrl.sv =====
// controller: sequences clearing, chain walks, header writes and byte requests
module era_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output era_pkg::ctrl_cmd_t cmd,
  input  era_pkg::dp_stat_t  stat
);
  import era_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_CHECK,
    S_ISSUE,
    S_CAPTURE,
    S_DECIDE,
    S_HDR,
    S_WOPEN,
    S_WBYTE,
    S_RB_ISSUE,
    S_RB_CAP,
    S_DONE
  } state_t;

  typedef enum logic {
    M_FIND,
    M_ALLOC
  } mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next;

  assign in_ready = (state == S_IDLE);

  // next state and datapath command
  always_comb begin
    state_next     = state;
    mode_next      = mode;
    cmd.op         = OP_NONE;
    cmd.set_status = 1'b0;
    cmd.status     = ST_OK;
    cmd.push       = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        mode_next  = M_FIND;
        state_next = S_DONE;
        cmd.set_status = 1'b1;
        cmd.status     = ST_NOTHING;
        case (stat.req_type)
          REQ_WOPEN, REQ_ROPEN, REQ_FREE: begin
            cmd.set_status = 1'b0;
            state_next     = S_CHECK;
          end
          REQ_WBYTE: begin
            if (stat.write_left_nz) begin
              cmd.set_status = 1'b0;
              state_next     = S_WBYTE;
            end
          end
          REQ_RBYTE: begin
            if (stat.read_left_nz) begin
              cmd.set_status = 1'b0;
              state_next     = S_RB_ISSUE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_CHECK: begin
        if (!stat.walk_end) begin
          state_next = S_ISSUE;
        end else if (mode == M_ALLOC) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NO_SPACE;
          state_next     = S_DONE;
        end else if (stat.req_type == REQ_WOPEN) begin
          cmd.op     = OP_START;
          mode_next  = M_ALLOC;
          state_next = S_CHECK;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
          state_next     = S_DONE;
        end
      end
      S_ISSUE: begin
        cmd.op     = OP_ISSUE;
        state_next = S_CAPTURE;
      end
      S_CAPTURE: begin
        cmd.op     = OP_CAPTURE;
        state_next = stat.k_last ? S_DECIDE : S_ISSUE;
      end
      S_DECIDE: begin
        if (mode == M_FIND) begin
          if (!stat.is_marker) begin
            // chain ended without a live match
            if (stat.req_type == REQ_WOPEN) begin
              cmd.op     = OP_START;
              mode_next  = M_ALLOC;
              state_next = S_CHECK;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOT_FOUND;
              state_next     = S_DONE;
            end
          end else if (!stat.is_freed && stat.id_match) begin
            cmd.set_status = 1'b1;
            state_next     = S_DONE;
            case (stat.req_type)
              REQ_WOPEN: cmd.status = ST_ID_EXISTS;
              REQ_ROPEN: begin
                if (stat.fits) begin
                  cmd.op     = OP_ROPEN;
                  cmd.status = ST_OK;
                end else begin
                  cmd.status = ST_RANGE;
                end
              end
              default: begin
                cmd.op     = OP_FREE;
                cmd.status = ST_OK;
              end
            endcase
          end else begin
            cmd.op     = OP_ADVANCE;
            state_next = S_CHECK;
          end
        end else begin
          if (!stat.is_marker || (stat.is_freed && stat.len_match)) begin
            if (stat.fits) begin
              cmd.op     = OP_KCLR;
              state_next = S_HDR;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NO_SPACE;
              state_next     = S_DONE;
            end
          end else begin
            cmd.op     = OP_ADVANCE;
            state_next = S_CHECK;
          end
        end
      end
      S_HDR: begin
        cmd.op = OP_HDR_WRITE;
        if (stat.k_last) begin
          state_next = S_WOPEN;
        end
      end
      S_WOPEN: begin
        cmd.op         = OP_WOPEN;
        cmd.set_status = 1'b1;
        cmd.status     = ST_OK;
        state_next     = S_DONE;
      end
      S_WBYTE: begin
        cmd.op         = OP_WBYTE;
        cmd.set_status = 1'b1;
        cmd.status     = ST_OK;
        state_next     = S_DONE;
      end
      S_RB_ISSUE: begin
        cmd.op     = OP_RB_ISSUE;
        state_next = S_RB_CAP;
      end
      S_RB_CAP: begin
        cmd.op         = OP_RB_CAPTURE;
        cmd.set_status = 1'b1;
        cmd.status     = ST_OK;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and walk mode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      mode  <= M_FIND;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  // after a result is handed over the next item can be taken
  a_push_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> in_ready)
    else $error("controller not idle after result handed over");

  // a new item is only loaded while no store clearing is in progress
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD) |-> (state == S_IDLE))
    else $error("item loaded outside idle");

endmodule

// ===== rtl/core/eeprom_record_allocator.sv =====
// top level of the record allocator: controller, datapath and channel wiring
//
// Requests arrive on req (valid/ready); each one gives exactly one result on rsp.
// Request types: write open, write byte, read open, read byte, free. Open and free
// requests walk the record chain from address 0, reading each 5-byte header
// through the single read port of the store; each header visited takes a bound
// check, five read/capture pairs and a decision. A write open whose id is not
// live walks the chain a second time and writes a new header where one fits.
// One item is handled at a time; the next item is taken once the result of
// the current one sits in the output register.
// After reset all 1024 bytes of the store are swept to 0xFF, one byte per cycle;
// req.ready stays low until the sweep is done.
// When rsp is stalled the finished result holds in the output register; one more
// item may be accepted and processed, and its result waits until the register
// frees up.
module eeprom_record_allocator (
  input logic    clk,
  input logic    rst,
  era_req_if.sink   req,
  era_rsp_if.source rsp
);
  import era_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  era_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  era_dpath u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .in_req_type         (req.req_type),
    .in_record_id        (req.record_id),
    .in_record_length    (req.record_length),
    .in_data_byte        (req.data_byte),
    .out_valid           (rsp.valid),
    .out_ready           (rsp.ready),
    .out_status          (rsp.status),
    .out_read_byte_value (rsp.read_byte_value),
    .out_granted_length  (rsp.granted_length),
    .out_record_address  (rsp.record_address)
  );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the record allocator: request driver, result monitor, predictor
module tb_top;
  import era_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000000;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] record_id;
    logic [9:0]  record_length;
    logic [7:0]  data_byte;
  } req_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte_value;
    logic [9:0] granted_length;
    logic [9:0] record_address;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  era_req_if req ();
  era_rsp_if rsp ();

  eeprom_record_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // predictor state
  logic [7:0]  shadow_store [STORE_BYTES];
  int unsigned wr_ptr, wr_left, rd_ptr, rd_left;

  req_item_t   pending_reqs[$];
  rsp_item_t   expected_rsps[$];
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned peek_byte(int unsigned a);
    if (a >= STORE_BYTES) return 8'hFF;
    return shadow_store[a];
  endfunction

  function automatic int unsigned peek_word(int unsigned a);
    return peek_byte(a) | (peek_byte(a + 1) << 8);
  endfunction

  function automatic void poke_byte(int unsigned a, int unsigned v);
    if (a < STORE_BYTES) shadow_store[a] = v[7:0];
  endfunction

  function automatic bit marker_at(int unsigned a);
    return (peek_byte(a) & 8'h7F) == MARK_LIVE;
  endfunction

  function automatic int unsigned next_header(int unsigned a);
    return a + HEADER_BYTES + peek_word(a + 3);
  endfunction

  // walk the chain for a live record with this id
  function automatic bit find_live_record(int unsigned id, output int unsigned addr);
    int unsigned a;
    a = 0;
    addr = 0;
    while (a < STORE_BYTES) begin
      if (!marker_at(a)) return 1'b0;
      if ((peek_byte(a) & MARK_FREED) == 0 && peek_word(a + 1) == id) begin
        addr = a;
        return 1'b1;
      end
      a = next_header(a);
    end
    return 1'b0;
  endfunction

  // expected result of one request, updating the shadow store
  function automatic rsp_item_t predict_allocation(req_item_t it);
    rsp_item_t   r;
    int unsigned a, id, len, stored, granted;
    bit          found;
    r = '0;
    r.status = ST_NOTHING;
    id = it.record_id;
    len = it.record_length;
    case (it.req_type)
      REQ_WOPEN: begin
        wr_left = 0;
        if (find_live_record(id, a)) begin
          r.status = ST_ID_EXISTS;
        end else begin
          found = 1'b0;
          a = 0;
          while (a < STORE_BYTES) begin
            if (!marker_at(a) ||
                ((peek_byte(a) & MARK_FREED) != 0 && peek_word(a + 3) == len)) begin
              found = 1'b1;
              break;
            end
            a = next_header(a);
          end
          if (!found || HEADER_BYTES + a + len >= STORE_BYTES) begin
            r.status = ST_NO_SPACE;
          end else begin
            poke_byte(a, MARK_LIVE);
            poke_byte(a + 1, id & 8'hFF);
            poke_byte(a + 2, id >> 8);
            poke_byte(a + 3, len & 8'hFF);
            poke_byte(a + 4, len >> 8);
            wr_ptr = a + HEADER_BYTES;
            wr_left = len;
            r.status = ST_OK;
            r.record_address = a[9:0];
          end
        end
      end
      REQ_WBYTE: begin
        if (wr_left != 0) begin
          poke_byte(wr_ptr, it.data_byte);
          wr_ptr++;
          wr_left--;
          r.status = ST_OK;
        end
      end
      REQ_ROPEN: begin
        rd_left = 0;
        if (!find_live_record(id, a)) begin
          r.status = ST_NOT_FOUND;
        end else if (HEADER_BYTES + a + len >= STORE_BYTES) begin
          r.status = ST_RANGE;
        end else begin
          stored = peek_word(a + 3);
          granted = stored < len ? stored : len;
          rd_ptr = a + HEADER_BYTES;
          rd_left = granted;
          r.status = ST_OK;
          r.granted_length = granted[9:0];
          r.record_address = a[9:0];
        end
      end
      REQ_RBYTE: begin
        if (rd_left != 0) begin
          r.read_byte_value = 8'(peek_byte(rd_ptr));
          rd_ptr++;
          rd_left--;
          r.status = ST_OK;
        end
      end
      REQ_FREE: begin
        if (!find_live_record(id, a)) begin
          r.status = ST_NOT_FOUND;
        end else begin
          poke_byte(a, MARK_LIVE | MARK_FREED);
          r.status = ST_OK;
          r.record_address = a[9:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit idle_now();
    // one long quiet window with no idling on either side
    if (cycle_count > 60000 && cycle_count < 160000) return 1'b0;
    return $urandom_range(0, 99) < 20;
  endfunction

  // request driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (req.valid)
        expected_rsps.push_back(predict_allocation({req.req_type, req.record_id,
                                                    req.record_length, req.data_byte}));
      if (pending_reqs.size() != 0 && !idle_now()) begin
        req_item_t nxt;
        nxt = pending_reqs.pop_front();
        req.valid         <= 1'b1;
        req.req_type      <= nxt.req_type;
        req.record_id     <= nxt.record_id;
        req.record_length <= nxt.record_length;
        req.data_byte     <= nxt.data_byte;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result status=%0d", $time, rsp.status);
          error_count++;
        end else begin
          rsp_item_t want;
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            error_count++;
          end
          if (rsp.read_byte_value !== want.read_byte_value) begin
            $display("%0t: read_byte_value expected %0h actual %0h", $time,
                     want.read_byte_value, rsp.read_byte_value);
            error_count++;
          end
          if (rsp.granted_length !== want.granted_length) begin
            $display("%0t: granted_length expected %0d actual %0d", $time,
                     want.granted_length, rsp.granted_length);
            error_count++;
          end
          if (rsp.record_address !== want.record_address) begin
            $display("%0t: record_address expected %0d actual %0d", $time,
                     want.record_address, rsp.record_address);
            error_count++;
          end
        end
      end
      rsp.ready <= !idle_now();
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("eeprom_record_allocator regression: fail");
      $finish;
    end
  end

  task automatic add_req(logic [2:0] t, logic [15:0] id, logic [9:0] len, logic [7:0] d);
    pending_reqs.push_back({t, id, len, d});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 15));
  endfunction

  function automatic logic [9:0] pick_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 2) return 10'd1019;
    if (p < 5) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(0, 8));
  endfunction

  // stimulus
  initial begin
    int unsigned made, n, k;
    logic [9:0]  len;
    req.valid = 1'b0;
    req.req_type = REQ_WOPEN;
    req.record_id = '0;
    req.record_length = '0;
    req.data_byte = '0;
    rsp.ready = 1'b0;
    for (int i = 0; i < STORE_BYTES; i++) shadow_store[i] = ERASED;
    wr_ptr = 0; wr_left = 0; rd_ptr = 0; rd_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: basic stream, id collision, reuse, limits, unused codes
    add_req(REQ_WBYTE, 16'd0, 10'd0, 8'h11);
    add_req(REQ_RBYTE, 16'd0, 10'd0, 8'h00);
    add_req(REQ_WOPEN, 16'd1, 10'd3, 8'h00);
    add_req(REQ_WBYTE, 16'd0, 10'd0, 8'h00);
    add_req(REQ_WBYTE, 16'd0, 10'd0, 8'hFF);
    add_req(REQ_WBYTE, 16'd0, 10'd0, 8'hA5);
    add_req(REQ_WBYTE, 16'd0, 10'd0, 8'h5A);
    add_req(REQ_ROPEN, 16'd1, 10'd10, 8'h00);
    add_req(REQ_RBYTE, 16'd0, 10'd0, 8'h00);
    add_req(REQ_RBYTE, 16'd0, 10'd0, 8'h00);
    add_req(REQ_RBYTE, 16'd0, 10'd0, 8'h00);
    add_req(REQ_RBYTE, 16'd0, 10'd0, 8'h00);
    add_req(REQ_WOPEN, 16'd1, 10'd3, 8'h00);
    add_req(REQ_FREE,  16'd1, 10'd0, 8'h00);
    add_req(REQ_FREE,  16'd1, 10'd0, 8'h00);
    add_req(REQ_ROPEN, 16'd1, 10'd1, 8'h00);
    add_req(REQ_WOPEN, 16'hFFFF, 10'd3, 8'h00);
    add_req(REQ_WOPEN, 16'd0, 10'd1019, 8'h00);
    add_req(REQ_WOPEN, 16'd7, 10'd1010, 8'h00);
    add_req(REQ_ROPEN, 16'hFFFF, 10'd1019, 8'h00);
    add_req(REQ_ROPEN, 16'hFFFF, 10'd0, 8'h00);
    add_req(3'd5, 16'hFFFF, 10'h3FF, 8'hFF);
    add_req(3'd6, 16'd0, 10'd0, 8'h00);
    add_req(3'd7, 16'd2, 10'd2, 8'h01);
    wait_drained();

    // random: mostly open/stream sequences, some noise, drained once over 200 are pending
    made = 0;
    while (made < 1950) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        len = pick_len();
        add_req(REQ_WOPEN, pick_id(), len, 8'($urandom));
        n = (len > 12) ? $urandom_range(0, 12) : len + $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
          add_req(REQ_WBYTE, 16'($urandom), 10'($urandom), 8'($urandom));
        made += n + 1;
      end else if (k < 75) begin
        add_req(REQ_ROPEN, pick_id(), pick_len(), 8'($urandom));
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++)
          add_req(REQ_RBYTE, 16'($urandom), 10'($urandom), 8'($urandom));
        made += n + 1;
      end else if (k < 90) begin
        add_req(REQ_FREE, pick_id(), 10'($urandom), 8'($urandom));
        made++;
      end else begin
        add_req(3'($urandom_range(0, 7)), 16'($urandom), 10'($urandom), 8'($urandom));
        made++;
      end
      if (pending_reqs.size() > 200) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_rsps.size() == 0)
      $display("eeprom_record_allocator regression: pass");
    else
      $display("eeprom_record_allocator regression: fail");
    $finish;
  end

endmodule
